/* hdl/escaped_packet_deframer_top_defines.svh */
// Assertion helpers for the deframer. They expect clk_i and rst_ni in scope.
`ifndef ESCAPED_PACKET_DEFRAMER_TOP_DEFINES_SVH
`define ESCAPED_PACKET_DEFRAMER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

`define EDF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("deframer assertion failed");

`define EDF_ASSERT_NEXT(lbl, cond, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (expr)) \
    else $error("deframer assertion failed");

`else

`define EDF_ASSERT(lbl, prop)

`define EDF_ASSERT_NEXT(lbl, cond, expr)

`endif

`endif

/* hdl/edf_pkg.sv */
package edf_pkg;

  localparam logic [7:0] START_BYTE = 8'h55;
  localparam logic [7:0] END_BYTE   = 8'hAA;
  localparam logic [7:0] ESC_BYTE   = 8'h5A;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_CSUM  = 2'd1;
  localparam logic [1:0] STATUS_ABORT = 2'd2;

  localparam logic [15:0] LEN_MAX = 16'hFFFF;

  localparam int CMD_DEPTH = 2;
  localparam int CMD_PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_START,
    OP_END,
    OP_DATA
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic avail;
  } fifo_stat_t;

  typedef struct packed {
    logic        is_end;
    logic [7:0]  payload_byte;
    logic [1:0]  end_status;
    logic [15:0] payload_length;
  } rec_t;

endpackage

/* hdl/edf_rx_if.sv */
interface edf_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

/* hdl/edf_rec_if.sv */
interface edf_rec_if;
  logic        valid;
  logic        ready;
  logic        is_end;
  logic [7:0]  payload_byte;
  logic [1:0]  end_status;
  logic [15:0] payload_length;

  modport source (output valid, output is_end, output payload_byte, output end_status,
                  output payload_length, input ready);
  modport sink (input valid, input is_end, input payload_byte, input end_status,
                input payload_length, output ready);
endinterface

/* hdl/escaped_packet_deframer_top.sv */
// Byte-stuffed frame receiver.
// rx_i carries one raw serial byte per request (valid/ready). rec_o carries one
// record per request: a payload byte (is_end = 0) or an end-of-packet status
// (is_end = 1) with the released payload length, saturating at 65535.
// 0x55 opens a packet, 0xAA closes it, 0x5A makes the next byte literal. Each
// payload byte is released when the following data byte arrives, so the
// trailing checksum byte never appears. Status: 0 ok, 1 bad checksum,
// 2 packet abandoned by a new start byte.
// Throughput: one byte per cycle sustained while rec_o keeps taking records.
// Path: an accepted byte is decoded into a two-entry command queue, and the
// head of the queue is processed into the output register.
// Stalls: the output register and the queue absorb up to three pending items;
// once the queue fills, rx_i.ready drops until rec_o is drained. Since
// ready comes from the registered fill count, it rises only after a pop.
// Reset (rst_ni low, asynchronous): outside any packet, no escape pending,
// queue and output register empty.
module escaped_packet_deframer_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  edf_rx_if.sink     rx_i,
  edf_rec_if.source  rec_o
);

  edf_pkg::fifo_stat_t stat;
  edf_pkg::cmd_t       push_cmd;
  edf_pkg::cmd_t       head_cmd;
  logic                push;
  logic                pop;

  edf_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_i),
    .stat_i (stat),
    .push_o (push),
    .cmd_o  (push_cmd)
  );

  edf_cmd_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (push_cmd),
    .pop_i  (pop),
    .cmd_o  (head_cmd),
    .stat_o (stat)
  );

  edf_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .cmd_i  (head_cmd),
    .pop_o  (pop),
    .rec_o  (rec_o)
  );

endmodule

/* hdl/edf_front.sv */
module edf_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  edf_rx_if.sink             rx_i,
  input  edf_pkg::fifo_stat_t stat_i,
  output logic               push_o,
  output edf_pkg::cmd_t      cmd_o
);

  logic esc_q, esc_d;
  logic accept;
  logic is_esc;

  assign rx_i.ready = !stat_i.full;
  assign accept     = rx_i.valid && rx_i.ready;
  // an unescaped escape byte only arms the literal flag, it never reaches the queue
  assign is_esc     = !esc_q && (rx_i.rx_byte == edf_pkg::ESC_BYTE);

  always_comb begin
    esc_d = esc_q;
    if (accept) begin
      esc_d = is_esc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q <= 1'b0;
    end else begin
      esc_q <= esc_d;
    end
  end

  always_comb begin
    cmd_o.data = rx_i.rx_byte;
    if (esc_q) begin
      cmd_o.op = edf_pkg::OP_DATA;
    end else if (rx_i.rx_byte == edf_pkg::START_BYTE) begin
      cmd_o.op = edf_pkg::OP_START;
    end else if (rx_i.rx_byte == edf_pkg::END_BYTE) begin
      cmd_o.op = edf_pkg::OP_END;
    end else begin
      cmd_o.op = edf_pkg::OP_DATA;
    end
  end

  assign push_o = accept && !is_esc;

endmodule

/* hdl/edf_cmd_fifo.sv */
`include "escaped_packet_deframer_top_defines.svh"

module edf_cmd_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  edf_pkg::cmd_t       cmd_i,
  input  logic                pop_i,
  output edf_pkg::cmd_t       cmd_o,
  output edf_pkg::fifo_stat_t stat_o
);

  localparam logic [edf_pkg::CMD_PTR_W-1:0] PtrLast = edf_pkg::CMD_PTR_W'(edf_pkg::CMD_DEPTH - 1);
  localparam logic [edf_pkg::CMD_CNT_W-1:0] CntFull = edf_pkg::CMD_CNT_W'(edf_pkg::CMD_DEPTH);

  edf_pkg::cmd_t mem_q [edf_pkg::CMD_DEPTH];

  logic [edf_pkg::CMD_PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [edf_pkg::CMD_CNT_W-1:0] cnt_q, cnt_d;
  logic do_push, do_pop;

  assign stat_o.full  = (cnt_q == CntFull);
  assign stat_o.avail = (cnt_q != '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && stat_o.avail;
  assign cmd_o        = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrLast) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrLast) ? '0 : rd_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  `EDF_ASSERT(a_cnt_bound, cnt_q <= CntFull)
  `EDF_ASSERT(a_no_push_full, !(push_i && stat_o.full))

endmodule

/* hdl/edf_back.sv */
`include "escaped_packet_deframer_top_defines.svh"

module edf_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  edf_pkg::fifo_stat_t stat_i,
  input  edf_pkg::cmd_t       cmd_i,
  output logic                pop_o,
  edf_rec_if.source           rec_o
);

  logic          in_pkt_q, in_pkt_d;
  logic [7:0]    sum_q, sum_d;
  logic [7:0]    held_q, held_d;
  logic          held_v_q, held_v_d;
  logic [15:0]   cnt_q, cnt_d;
  logic          out_v_q, out_v_d;
  edf_pkg::rec_t out_q, out_d;
  logic          emit;
  edf_pkg::rec_t rec;

  // output register frees up when empty or being drained this cycle
  assign pop_o = stat_i.avail && (!out_v_q || rec_o.ready);

  always_comb begin
    in_pkt_d = in_pkt_q;
    sum_d    = sum_q;
    held_d   = held_q;
    held_v_d = held_v_q;
    cnt_d    = cnt_q;
    emit     = 1'b0;
    rec      = '0;
    if (pop_o) begin
      case (cmd_i.op)
        edf_pkg::OP_START: begin
          if (in_pkt_q) begin
            emit               = 1'b1;
            rec.is_end         = 1'b1;
            rec.end_status     = edf_pkg::STATUS_ABORT;
            rec.payload_length = cnt_q;
          end
          in_pkt_d = 1'b1;
          sum_d    = '0;
          held_d   = '0;
          held_v_d = 1'b0;
          cnt_d    = '0;
        end
        edf_pkg::OP_END: begin
          if (in_pkt_q) begin
            emit               = 1'b1;
            rec.is_end         = 1'b1;
            rec.end_status     = (sum_q != '0) ? edf_pkg::STATUS_CSUM : edf_pkg::STATUS_OK;
            rec.payload_length = cnt_q;
            in_pkt_d           = 1'b0;
            sum_d              = '0;
            held_d             = '0;
            held_v_d           = 1'b0;
            cnt_d              = '0;
          end
        end
        edf_pkg::OP_DATA: begin
          if (in_pkt_q) begin
            sum_d    = sum_q + cmd_i.data;
            held_d   = cmd_i.data;
            held_v_d = 1'b1;
            // release the previous byte; the last one held is the checksum
            if (held_v_q) begin
              emit             = 1'b1;
              rec.payload_byte = held_q;
              if (cnt_q != edf_pkg::LEN_MAX) begin
                cnt_d = cnt_q + 16'd1;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_v_d = out_v_q;
    out_d   = out_q;
    if (emit) begin
      out_v_d = 1'b1;
      out_d   = rec;
    end else if (rec_o.ready) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_pkt_q <= 1'b0;
      sum_q    <= '0;
      held_q   <= '0;
      held_v_q <= 1'b0;
      cnt_q    <= '0;
      out_v_q  <= 1'b0;
    end else begin
      in_pkt_q <= in_pkt_d;
      sum_q    <= sum_d;
      held_q   <= held_d;
      held_v_q <= held_v_d;
      cnt_q    <= cnt_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign rec_o.valid          = out_v_q;
  assign rec_o.is_end         = out_q.is_end;
  assign rec_o.payload_byte   = out_q.payload_byte;
  assign rec_o.end_status     = out_q.end_status;
  assign rec_o.payload_length = out_q.payload_length;

  `EDF_ASSERT(a_end_rec_no_byte, !(out_v_q && out_q.is_end && out_q.payload_byte != '0))
  `EDF_ASSERT(a_data_rec_clean,
              !(out_v_q && !out_q.is_end && (out_q.end_status != '0 || out_q.payload_length != '0)))
  `EDF_ASSERT_NEXT(a_end_closes, pop_o && cmd_i.op == edf_pkg::OP_END, !in_pkt_q)
  `EDF_ASSERT_NEXT(a_start_opens, pop_o && cmd_i.op == edf_pkg::OP_START,
                   in_pkt_q && !held_v_q && cnt_q == '0)

endmodule

/* test/edf_record_checker.sv */
module edf_record_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          rx_valid_i,
  input  logic          rx_ready_i,
  input  logic [7:0]    rx_byte_i,
  input  logic          rec_valid_i,
  input  logic          rec_ready_i,
  input  edf_pkg::rec_t rec_i,
  output int unsigned   mismatch_count_o,
  output int unsigned   pending_o
);

  // Deframer state as seen from the byte stream.
  logic        in_pkt;
  logic        esc_pending;
  logic [7:0]  pkt_sum;
  logic [7:0]  held_byte;
  logic        held_valid;
  logic [15:0] released_cnt;

  edf_pkg::rec_t expected_records[$];
  edf_pkg::rec_t want;

  task automatic expect_rec(input edf_pkg::rec_t r);
    expected_records.insert(expected_records.size(), r);
  endtask

  task automatic clear_frame();
    in_pkt       = 1'b0;
    esc_pending  = 1'b0;
    pkt_sum      = '0;
    held_byte    = '0;
    held_valid   = 1'b0;
    released_cnt = '0;
  endtask

  task automatic deframe_byte(input logic [7:0] b);
    logic literal;
    edf_pkg::rec_t r;
    literal     = esc_pending;
    esc_pending = 1'b0;
    r           = '0;
    if (!literal && b == edf_pkg::START_BYTE) begin
      if (in_pkt) begin
        r.is_end         = 1'b1;
        r.end_status     = edf_pkg::STATUS_ABORT;
        r.payload_length = released_cnt;
        expect_rec(r);
      end
      clear_frame();
      in_pkt = 1'b1;
    end else if (!literal && b == edf_pkg::END_BYTE) begin
      if (in_pkt) begin
        r.is_end         = 1'b1;
        r.end_status     = (pkt_sum != 8'd0) ? edf_pkg::STATUS_CSUM : edf_pkg::STATUS_OK;
        r.payload_length = released_cnt;
        expect_rec(r);
        clear_frame();
      end
    end else if (!literal && b == edf_pkg::ESC_BYTE) begin
      esc_pending = 1'b1;
    end else if (in_pkt) begin
      pkt_sum = pkt_sum + b;
      // the previous data byte goes out only once we know it is not the checksum
      if (held_valid) begin
        r.payload_byte = held_byte;
        expect_rec(r);
        if (released_cnt != edf_pkg::LEN_MAX) released_cnt = released_cnt + 16'd1;
      end
      held_byte  = b;
      held_valid = 1'b1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_frame();
      expected_records.delete();
      mismatch_count_o = 0;
      pending_o <= 0;
    end else begin
      if (rx_valid_i && rx_ready_i) deframe_byte(rx_byte_i);
      if (rec_valid_i && rec_ready_i) begin
        if (expected_records.size() == 0) begin
          $error("record with none expected: is_end %0d payload_byte %0h end_status %0d len %0d",
                 rec_i.is_end, rec_i.payload_byte, rec_i.end_status, rec_i.payload_length);
          mismatch_count_o++;
        end else begin
          want = expected_records.pop_front();
          if (rec_i.is_end !== want.is_end) begin
            $error("is_end: expected %0d, got %0d", want.is_end, rec_i.is_end);
            mismatch_count_o++;
          end
          if (rec_i.payload_byte !== want.payload_byte) begin
            $error("payload_byte: expected %0h, got %0h", want.payload_byte, rec_i.payload_byte);
            mismatch_count_o++;
          end
          if (rec_i.end_status !== want.end_status) begin
            $error("end_status: expected %0d, got %0d", want.end_status, rec_i.end_status);
            mismatch_count_o++;
          end
          if (rec_i.payload_length !== want.payload_length) begin
            $error("payload_length: expected %0d, got %0d",
                   want.payload_length, rec_i.payload_length);
            mismatch_count_o++;
          end
        end
      end
      pending_o <= expected_records.size();
    end
  end

endmodule

/* test/escaped_packet_deframer_top_test.sv */
module escaped_packet_deframer_top_test;

  localparam int RANDOM_BYTES = 810;

  logic clk_i;
  logic rst_ni;

  edf_rx_if  rx_bus ();
  edf_rec_if rec_bus ();

  edf_pkg::rec_t rec_view;
  int unsigned   mismatch_count;
  int unsigned   pending;

  logic [7:0] stim_q[$];

  assign rec_view.is_end         = rec_bus.is_end;
  assign rec_view.payload_byte   = rec_bus.payload_byte;
  assign rec_view.end_status     = rec_bus.end_status;
  assign rec_view.payload_length = rec_bus.payload_length;

  escaped_packet_deframer_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_bus),
    .rec_o  (rec_bus)
  );

  edf_record_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .rx_valid_i       (rx_bus.valid),
    .rx_ready_i       (rx_bus.ready),
    .rx_byte_i        (rx_bus.rx_byte),
    .rec_valid_i      (rec_bus.valid),
    .rec_ready_i      (rec_bus.ready),
    .rec_i            (rec_view),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("** escaped_packet_deframer_top: FAILED **");
    $finish;
  end

  task automatic put_byte(input logic [7:0] b);
    stim_q.insert(stim_q.size(), b);
  endtask

  function automatic logic [7:0] pick_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 2))
        0:       b = edf_pkg::START_BYTE;
        1:       b = edf_pkg::END_BYTE;
        default: b = edf_pkg::ESC_BYTE;
      endcase
    end
    return b;
  endfunction

  // data byte inside a packet, escaped when it would read as a control byte and at random otherwise
  task automatic add_data(input logic [7:0] b);
    if (b == edf_pkg::START_BYTE || b == edf_pkg::END_BYTE || b == edf_pkg::ESC_BYTE ||
        $urandom_range(0, 15) == 0)
      put_byte(edf_pkg::ESC_BYTE);
    put_byte(b);
  endtask

  // n data bytes, the last one being the checksum
  task automatic add_packet(input int n, input bit good_csum, input bit close);
    logic [7:0] s;
    logic [7:0] b;
    s = '0;
    put_byte(edf_pkg::START_BYTE);
    for (int k = 0; k < n - 1; k++) begin
      b = pick_byte();
      s = s + b;
      add_data(b);
    end
    if (n > 0) add_data(good_csum ? 8'd0 - s : 8'($urandom_range(0, 255)));
    if (close) put_byte(edf_pkg::END_BYTE);
  endtask

  task automatic build_stimulus();
    int stop_at;
    int n;
    // empty packet, then noise outside a packet including escaped controls
    put_byte(edf_pkg::START_BYTE); put_byte(edf_pkg::END_BYTE);
    put_byte(edf_pkg::END_BYTE); put_byte(8'h00); put_byte(8'hFF);
    put_byte(edf_pkg::ESC_BYTE); put_byte(edf_pkg::START_BYTE);
    put_byte(edf_pkg::ESC_BYTE); put_byte(edf_pkg::END_BYTE);
    // escaped start, end and escape as payload; checksum 0xA7 makes it good
    put_byte(edf_pkg::START_BYTE);
    put_byte(edf_pkg::ESC_BYTE); put_byte(edf_pkg::START_BYTE);
    put_byte(edf_pkg::ESC_BYTE); put_byte(edf_pkg::END_BYTE);
    put_byte(edf_pkg::ESC_BYTE); put_byte(edf_pkg::ESC_BYTE);
    put_byte(8'hA7); put_byte(edf_pkg::END_BYTE);
    // bad checksum with extreme values
    put_byte(edf_pkg::START_BYTE); put_byte(8'h00);
    put_byte(8'hFF); put_byte(edf_pkg::END_BYTE);
    // abandoned by a new start, then that packet closes empty
    put_byte(edf_pkg::START_BYTE); put_byte(8'h10); put_byte(8'h20);
    put_byte(edf_pkg::START_BYTE); put_byte(edf_pkg::END_BYTE);
    // escaped end as the only data byte
    put_byte(edf_pkg::START_BYTE); put_byte(edf_pkg::ESC_BYTE);
    put_byte(edf_pkg::END_BYTE); put_byte(edf_pkg::END_BYTE);

    stop_at = stim_q.size() + RANDOM_BYTES;
    while (stim_q.size() < stop_at) begin
      if ($urandom_range(0, 9) < 7) begin
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(11, 40) : $urandom_range(0, 10);
        add_packet(n, $urandom_range(0, 3) != 0, $urandom_range(0, 9) != 0);
      end else if ($urandom_range(0, 2) == 0) begin
        put_byte(edf_pkg::ESC_BYTE);
        put_byte($urandom_range(0, 1) ? edf_pkg::START_BYTE : edf_pkg::END_BYTE);
      end else begin
        repeat ($urandom_range(1, 4)) put_byte(pick_byte());
      end
    end

    // close anything left open, then one last clean packet
    put_byte(edf_pkg::END_BYTE);
    add_packet(3, 1'b1, 1'b1);
  endtask

  // request sender
  initial begin
    int gap;
    rst_ni         <= 1'b0;
    rx_bus.valid   <= 1'b0;
    rx_bus.rx_byte <= '0;
    build_stimulus();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < stim_q.size(); i++) begin
      gap = ((i / 64) % 5 == 4) ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
        rx_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      rx_bus.valid   <= 1'b1;
      rx_bus.rx_byte <= stim_q[i];
      @(posedge clk_i);
      while (!rx_bus.ready) @(posedge clk_i);
    end
    rx_bus.valid <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);

    if (mismatch_count == 0 && pending == 0) begin
      $display("** escaped_packet_deframer_top: PASSED **");
    end else begin
      $display("** escaped_packet_deframer_top: FAILED **");
    end
    $finish;
  end

  // record receiver
  initial begin
    int unsigned n_recv;
    int          hold;
    n_recv = 0;
    rec_bus.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      // long hold-offs let the queue fill and back up into rx
      hold = (n_recv == 150 || n_recv == 600) ? 150 : 0;
      hold = hold + (((n_recv / 50) % 4 == 3) ? 0 : $urandom_range(0, 4));
      if (hold > 0) begin
        rec_bus.ready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      rec_bus.ready <= 1'b1;
      @(posedge clk_i);
      while (!rec_bus.valid) @(posedge clk_i);
      n_recv++;
    end
  end

endmodule
